// ----- rtl/fwtd_pkg.sv -----
// fwtd_pkg: shared types and constants of the fixed width text decoder
// no dependencies; imported by every module of the block but fwtd_ram

package fwtd_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int CP_W        = 21;
  localparam int OUT_W       = 24;
  localparam int CP_PAD      = OUT_W - CP_W;
  localparam int MODE_W      = 3;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // decode modes
  localparam logic [MODE_W-1:0] MODE_CP    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_U16LE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_U16BE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_U32LE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_U32BE = 3'd4;

  // input commands
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_DECODE_MODE = 1'b0;

  typedef struct packed {
    logic [OUT_W-1:0] code_point;
    logic             char_valid;
    logic             stream_end;
    logic [1:0]       dropped_bytes;
  } fwtd_res_t;

endpackage

// ----- rtl/fwtd_ram.sv -----
// fwtd_ram: generic single write port RAM with registered read
// no dependencies

module fwtd_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fwtd_front.sv -----
// fwtd_front: accepts input transactions, assembles utf16/utf32 units,
// owns the code page table and resolves lookups; depends on fwtd_pkg, fwtd_ram

module fwtd_front #(
  parameter int QUEUE_DEPTH = 4,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               command_i,
  input  logic [7:0]                         byte_value_i,
  input  logic [fwtd_pkg::TABLE_AW-1:0]      entry_index_i,
  input  logic [fwtd_pkg::CP_W-1:0]          entry_code_point_i,
  input  logic                               end_of_stream_i,
  input  logic [fwtd_pkg::MODE_W-1:0]        mode_i,
  input  logic                               clear_i,
  input  logic [CW-1:0]                      q_count_i,
  output logic                               push_o,
  output fwtd_pkg::fwtd_res_t                push_res_o
);

  import fwtd_pkg::*;

  logic             accept;
  logic             is_data;
  logic [CW:0]      occupancy;
  logic [OUT_W-1:0] asm_q, asm_d, asm_nx;
  logic [1:0]       cnt_q, cnt_d;
  logic [2:0]       cnt_nx;
  logic             little, short_unit, unit_done;
  logic             emit, lookup;
  fwtd_res_t        res;
  logic             s1_valid_q, s1_lookup_q;
  fwtd_res_t        s1_res_q;
  logic             tbl_we, tbl_re;
  logic [CP_W-1:0]  tbl_rdata;

  // lookup stage plus queue must have room for everything in flight
  assign occupancy  = {1'b0, q_count_i} + (CW + 1)'(s1_valid_q);
  assign in_stall_o = occupancy >= (CW + 1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_data    = command_i == CMD_DATA;

  assign tbl_we = accept & (command_i == CMD_WRITE);
  assign tbl_re = accept & is_data & (mode_i == MODE_CP) & byte_value_i[7];

  fwtd_ram #(
    .WIDTH (CP_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (entry_index_i),
    .wdata_i (entry_code_point_i),
    .re_i    (tbl_re),
    .raddr_i (byte_value_i[TABLE_AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  assign little     = (mode_i == MODE_U16LE) || (mode_i == MODE_U32LE);
  assign short_unit = (mode_i == MODE_U16LE) || (mode_i == MODE_U16BE);
  assign cnt_nx     = {1'b0, cnt_q} + 3'd1;
  assign unit_done  = short_unit ? (cnt_nx >= 3'd2) : (cnt_nx == 3'd4);

  // little endian places byte k at bit 8k, a fourth byte falls off
  always_comb begin
    if (little) begin
      case (cnt_q)
        2'd0:    asm_nx = asm_q | {16'd0, byte_value_i};
        2'd1:    asm_nx = asm_q | {8'd0, byte_value_i, 8'd0};
        2'd2:    asm_nx = asm_q | {byte_value_i, 16'd0};
        default: asm_nx = asm_q;
      endcase
    end else begin
      asm_nx = {asm_q[OUT_W-9:0], byte_value_i};
    end
  end

  always_comb begin
    asm_d  = asm_q;
    cnt_d  = cnt_q;
    res    = '0;
    emit   = 1'b0;
    lookup = 1'b0;
    if (clear_i) begin
      asm_d = '0;
      cnt_d = '0;
    end else if (accept && is_data) begin
      case (mode_i)
        MODE_CP: begin
          emit           = 1'b1;
          res.char_valid = 1'b1;
          res.stream_end = end_of_stream_i;
          if (byte_value_i[7]) begin
            lookup = 1'b1;
          end else begin
            res.code_point = {16'd0, byte_value_i};
          end
        end
        MODE_U16LE, MODE_U16BE, MODE_U32LE, MODE_U32BE: begin
          if (unit_done) begin
            emit           = 1'b1;
            res.char_valid = 1'b1;
            res.stream_end = end_of_stream_i;
            res.code_point = short_unit ? {8'd0, asm_nx[15:0]} : asm_nx;
            asm_d          = '0;
            cnt_d          = '0;
          end else if (end_of_stream_i) begin
            emit              = 1'b1;
            res.stream_end    = 1'b1;
            res.dropped_bytes = cnt_nx[1:0];
            asm_d             = '0;
            cnt_d             = '0;
          end else begin
            asm_d = asm_nx;
            cnt_d = cnt_nx[1:0];
          end
        end
        default: begin
          // undefined modes only report the end of the stream
          if (end_of_stream_i) begin
            emit           = 1'b1;
            res.stream_end = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q      <= '0;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      asm_q      <= asm_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_lookup_q <= lookup;
    s1_res_q    <= res;
  end

  always_comb begin
    push_o     = s1_valid_q;
    push_res_o = s1_res_q;
    if (s1_lookup_q) begin
      push_res_o.code_point = {{CP_PAD{1'b0}}, tbl_rdata};
    end
  end

endmodule

// ----- rtl/fwtd_queue.sv -----
// fwtd_queue: result queue between the front part and the output channel
// depends on fwtd_pkg

module fwtd_queue #(
  parameter int DEPTH = 4,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int PW   = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fwtd_pkg::fwtd_res_t push_res_i,
  output logic [CW-1:0]       count_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fwtd_pkg::fwtd_res_t head_o
);

  import fwtd_pkg::*;

  fwtd_res_t     mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          pop;

  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o & ~out_stall_i;
  assign head_o      = mem_q[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    case ({push_i, pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_res_i;
    end
  end

endmodule

// ----- rtl/fixed_width_text_decoder.sv -----
// fixed_width_text_decoder: top level with the decode_mode register port
// depends on fwtd_pkg, fwtd_front, fwtd_queue (and fwtd_ram below fwtd_front)

// Turns a byte stream into code points in code page, utf16 le/be or utf32 le/be
// mode. One input transaction is taken per clock cycle while in_stall_o is low;
// a result goes through the table read stage register (the registered read of
// the 128-entry code page table for lookups) and then the result queue. Input
// stalls once the table read stage and the queue together hold QUEUE_DEPTH
// results, so a stalled output buffers QUEUE_DEPTH results before the input
// stops. Table writes travel as input transactions and take effect in stream
// order. decode_mode is written over the register port and restarts unit
// assembly; the user must write it only while the block is idle (not enforced).

module fixed_width_text_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fwtd_pkg::APB_AW-1:0]    paddr,
  input  logic [fwtd_pkg::APB_DW-1:0]    pwdata,
  output logic [fwtd_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [7:0]                     byte_value_i,
  input  logic [fwtd_pkg::TABLE_AW-1:0]  entry_index_i,
  input  logic [fwtd_pkg::CP_W-1:0]      entry_code_point_i,
  input  logic                           end_of_stream_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fwtd_pkg::OUT_W-1:0]     code_point_o,
  output logic                           char_valid_o,
  output logic                           stream_end_o,
  output logic [1:0]                     dropped_bytes_o
);

  import fwtd_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [MODE_W-1:0] mode_q;
  logic              reg_hit, mode_wr;
  logic [CW-1:0]     q_count;
  logic              push;
  fwtd_res_t         push_res, head;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == REG_DECODE_MODE;
  assign mode_wr = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? {{(APB_DW - MODE_W){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CP;
    end else if (mode_wr) begin
      mode_q <= pwdata[MODE_W-1:0];
    end
  end

  fwtd_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .byte_value_i       (byte_value_i),
    .entry_index_i      (entry_index_i),
    .entry_code_point_i (entry_code_point_i),
    .end_of_stream_i    (end_of_stream_i),
    .mode_i             (mode_q),
    .clear_i            (mode_wr),
    .q_count_i          (q_count),
    .push_o             (push),
    .push_res_o         (push_res)
  );

  fwtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_res_i  (push_res),
    .count_o     (q_count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign code_point_o    = head.code_point;
  assign char_valid_o    = head.char_valid;
  assign stream_end_o    = head.stream_end;
  assign dropped_bytes_o = head.dropped_bytes;

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for fixed_width_text_decoder
// depends on fwtd_pkg and the rtl of the block; predicts results in-line, but directed check rows carry their own
`timescale 1ns / 100ps

module tb;
  import fwtd_pkg::*;

  localparam int LIMIT_CYCLES    = 500_000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int LONG_HOLD       = 80;
  localparam int N_PHASES        = 20;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int N_DIRECTED      = 34;
  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  // codes 5..7 are not defined as decode modes
  localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;
  localparam logic [APB_AW-1:0] MODE_ADDR = {REG_DECODE_MODE, 2'b00};
  localparam logic [MODE_W-1:0] MODE_ORDER [6] = '{MODE_CP, MODE_U16LE, MODE_U16BE,
                                                   MODE_U32LE, MODE_U32BE, MODE_UNDEF_LO};

  typedef struct packed {
    logic                cmd;
    logic [7:0]          data_byte;
    logic [TABLE_AW-1:0] idx;
    logic [CP_W-1:0]     cp;
    logic                eos;
  } stim_t;

  typedef struct packed {
    bit        typed;
    fwtd_res_t want;
  } stim_note_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_MODE} row_kind_e;

  // mode rows carry the new decode_mode in data_byte
  typedef struct packed {
    row_kind_e kind;
    stim_t     s;
    fwtd_res_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_CHECK, '{CMD_DATA,  8'h00, 7'd0,   21'h0,      1'b0}, '{24'h000000, 1'b1, 1'b0, 2'd0}},
    '{ROW_CHECK, '{CMD_DATA,  8'h7F, 7'd0,   21'h0,      1'b0}, '{24'h00007F, 1'b1, 1'b0, 2'd0}},
    '{ROW_ITEM,  '{CMD_WRITE, 8'h00, 7'd0,   21'h10FFFF, 1'b0}, '0},
    '{ROW_ITEM,  '{CMD_WRITE, 8'h00, 7'd127, 21'h0,      1'b0}, '0},
    '{ROW_CHECK, '{CMD_DATA,  8'h80, 7'd0,   21'h0,      1'b0}, '{24'h10FFFF, 1'b1, 1'b0, 2'd0}},
    '{ROW_CHECK, '{CMD_DATA,  8'hFF, 7'd0,   21'h0,      1'b1}, '{24'h000000, 1'b1, 1'b1, 2'd0}},
    '{ROW_MODE,  '{CMD_DATA,  {5'd0, MODE_U16LE}, 7'd0, 21'h0, 1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'h34, 7'd0,   21'h0,      1'b0}, '0},
    // rewriting the mode drops the half-built unit
    '{ROW_MODE,  '{CMD_DATA,  {5'd0, MODE_U16LE}, 7'd0, 21'h0, 1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'h34, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_CHECK, '{CMD_DATA,  8'h12, 7'd0,   21'h0,      1'b0}, '{24'h001234, 1'b1, 1'b0, 2'd0}},
    '{ROW_CHECK, '{CMD_DATA,  8'hFF, 7'd0,   21'h0,      1'b1}, '{24'h000000, 1'b0, 1'b1, 2'd1}},
    '{ROW_MODE,  '{CMD_DATA,  {5'd0, MODE_U16BE}, 7'd0, 21'h0, 1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'hD8, 7'd0,   21'h0,      1'b0}, '0},
    // table write in the middle of a unit leaves the unit alone
    '{ROW_ITEM,  '{CMD_WRITE, 8'h00, 7'd5,   21'h000041, 1'b0}, '0},
    '{ROW_CHECK, '{CMD_DATA,  8'h3D, 7'd0,   21'h0,      1'b1}, '{24'h00D83D, 1'b1, 1'b1, 2'd0}},
    '{ROW_MODE,  '{CMD_DATA,  {5'd0, MODE_U32LE}, 7'd0, 21'h0, 1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'hFF, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'hFF, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'h10, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_CHECK, '{CMD_DATA,  8'hAB, 7'd0,   21'h0,      1'b0}, '{24'h10FFFF, 1'b1, 1'b0, 2'd0}},
    '{ROW_ITEM,  '{CMD_DATA,  8'h01, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'h02, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_CHECK, '{CMD_DATA,  8'h03, 7'd0,   21'h0,      1'b1}, '{24'h000000, 1'b0, 1'b1, 2'd3}},
    '{ROW_MODE,  '{CMD_DATA,  {5'd0, MODE_U32BE}, 7'd0, 21'h0, 1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'h12, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'hFF, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'hFF, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_CHECK, '{CMD_DATA,  8'hFF, 7'd0,   21'h0,      1'b0}, '{24'hFFFFFF, 1'b1, 1'b0, 2'd0}},
    '{ROW_MODE,  '{CMD_DATA,  {5'd0, MODE_UNDEF_HI}, 7'd0, 21'h0, 1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'h55, 7'd0,   21'h0,      1'b0}, '0},
    '{ROW_CHECK, '{CMD_DATA,  8'hAA, 7'd0,   21'h0,      1'b1}, '{24'h000000, 1'b0, 1'b1, 2'd0}},
    '{ROW_MODE,  '{CMD_DATA,  {5'd0, MODE_CP}, 7'd0, 21'h0, 1'b0}, '0},
    '{ROW_ITEM,  '{CMD_DATA,  8'h85, 7'd0,   21'h0,      1'b0}, '0}
  };

  logic                clk_i;
  logic                rst_ni             = 1'b0;
  logic                psel               = 1'b0;
  logic                penable            = 1'b0;
  logic                pwrite             = 1'b0;
  logic [APB_AW-1:0]   paddr              = '0;
  logic [APB_DW-1:0]   pwdata             = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic                command_i          = CMD_DATA;
  logic [7:0]          byte_value_i       = '0;
  logic [TABLE_AW-1:0] entry_index_i      = '0;
  logic [CP_W-1:0]     entry_code_point_i = '0;
  logic                end_of_stream_i    = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic [OUT_W-1:0]    code_point_o;
  logic                char_valid_o;
  logic                stream_end_o;
  logic [1:0]          dropped_bytes_o;

  fixed_width_text_decoder i_dut (.*);

  // predictor state
  logic [CP_W-1:0]   cp_table [TABLE_DEPTH];
  logic [OUT_W-1:0]  unit_acc   = '0;
  logic [1:0]        unit_bytes = '0;
  logic [MODE_W-1:0] model_mode = MODE_CP;

  // generator side: slots that may be looked up
  bit         slot_loaded [TABLE_DEPTH];
  fwtd_res_t  pending_chars [$];
  stim_note_t stim_notes [$];

  int mismatches    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int mode_writes   = 0;
  int cycle_count   = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit predict_code_point(input stim_t s, output fwtd_res_t r);
    int k;
    bit short_unit;
    r = '0;
    if (s.cmd == CMD_WRITE) begin
      cp_table[s.idx] = s.cp;
      return 1'b0;
    end
    if (model_mode == MODE_CP) begin
      r.code_point = s.data_byte[7] ? {{CP_PAD{1'b0}}, cp_table[s.data_byte[6:0]]}
                                    : {16'h0, s.data_byte};
      r.char_valid = 1'b1;
      r.stream_end = s.eos;
      return 1'b1;
    end
    if (model_mode > MODE_U32BE) begin
      r.stream_end = s.eos;
      return s.eos;
    end
    short_unit = (model_mode <= MODE_U16BE);
    k = unit_bytes;
    if (model_mode == MODE_U16LE || model_mode == MODE_U32LE) begin
      // fourth byte of a little endian utf32 unit is the discarded top byte
      if (k < 3) unit_acc = unit_acc | ({16'h0, s.data_byte} << (8 * k));
    end else begin
      unit_acc = {unit_acc[15:0], s.data_byte};
    end
    k++;
    if (k >= (short_unit ? 2 : 4)) begin
      r.code_point = short_unit ? {8'h0, unit_acc[15:0]} : unit_acc;
      r.char_valid = 1'b1;
      r.stream_end = s.eos;
      unit_acc = '0;
      unit_bytes = '0;
      return 1'b1;
    end
    if (s.eos) begin
      r.stream_end = 1'b1;
      r.dropped_bytes = 2'(k);
      unit_acc = '0;
      unit_bytes = '0;
      return 1'b1;
    end
    unit_bytes = 2'(k);
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic stim_t random_item(input logic [MODE_W-1:0] mode);
    stim_t s;
    int write_pct;
    int eos_pct;
    write_pct = (mode == MODE_CP) ? 12 : 4;
    eos_pct = (mode > MODE_U32BE) ? 20 : (mode == MODE_CP) ? 5 : 6;
    s.data_byte = 8'($urandom_range(255));
    s.idx = TABLE_AW'($urandom_range(TABLE_DEPTH - 1));
    s.cp = CP_W'($urandom_range(CP_MAX));
    if ($urandom_range(99) < write_pct) begin
      s.cmd = CMD_WRITE;
      s.eos = 1'($urandom_range(1));
    end else begin
      s.cmd = CMD_DATA;
      s.eos = ($urandom_range(99) < eos_pct);
    end
    return s;
  endfunction

  // scoreboard: outputs are checked before this edge's input is predicted
  always @(posedge clk_i) begin
    fwtd_res_t got;
    fwtd_res_t want;
    fwtd_res_t pred;
    stim_note_t note;
    stim_t s;
    bit has_pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{code_point_o, char_valid_o, stream_end_o, dropped_bytes_o};
        results_seen++;
        if (pending_chars.size() == 0) begin
          $display("%0t: result with nothing expected: expected none got cp 0x%0h v%0b e%0b d%0d",
                   $time, got.code_point, got.char_valid, got.stream_end, got.dropped_bytes);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          check_field("code_point", 32'(want.code_point), 32'(got.code_point));
          check_field("char_valid", 32'(want.char_valid), 32'(got.char_valid));
          check_field("stream_end", 32'(want.stream_end), 32'(got.stream_end));
          check_field("dropped_bytes", 32'(want.dropped_bytes), 32'(got.dropped_bytes));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        s = '{command_i, byte_value_i, entry_index_i, entry_code_point_i, end_of_stream_i};
        note = stim_notes.pop_front();
        has_pred = predict_code_point(s, pred);
        if (note.typed) pending_chars.push_back(note.want);
        else if (has_pred) pending_chars.push_back(pred);
      end
    end
  end

  // output side back-pressure; a long hold is counted here
  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_chars.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input stim_t s, input bit typed, input fwtd_res_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= s.cmd;
    byte_value_i       <= s.data_byte;
    entry_index_i      <= s.idx;
    entry_code_point_i <= s.cp;
    end_of_stream_i    <= s.eos;
    stim_notes.push_back('{typed, want});
    if (s.cmd == CMD_WRITE) slot_loaded[s.idx] = 1'b1;
    items_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
    // table writes and partial units leave no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] mode);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= APB_DW'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    model_mode = mode;
    unit_acc = '0;
    unit_bytes = '0;
    mode_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("decode_mode readback", APB_DW'(mode), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    dir_row_t row;
    stim_t s;
    stim_t fill;
    logic [MODE_W-1:0] mode;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_MODE) write_mode(row.s.data_byte[MODE_W-1:0]);
      else send_item(row.s, row.kind == ROW_CHECK, row.want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      mode = MODE_ORDER[p % 6];
      if (mode == MODE_UNDEF_LO) mode = MODE_W'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
      write_mode(mode);
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 87;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 87;
        end
        default: begin
          tx_idle_pct = 19;
          rx_stall_pct = 19;
        end
      endcase
      // output held off while input keeps coming, so the block backs up
      if (p == 0) hold_requests++;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        s = random_item(mode);
        if (mode == MODE_CP && s.cmd == CMD_DATA && s.data_byte[7] &&
            !slot_loaded[s.data_byte[6:0]]) begin
          fill = s;
          fill.cmd = CMD_WRITE;
          fill.idx = s.data_byte[6:0];
          fill.eos = 1'b0;
          send_item(fill, 1'b0, '0);
        end
        send_item(s, 1'b0, '0);
      end
    end

    wait_drained();
    $display("run covered %0d input transactions over %0d decode_mode writes, %0d results",
             items_sent, mode_writes, results_seen);
    $display("modes: code page, utf16 le/be, utf32 le/be and undefined codes, with stalls");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
